@@ hw/rtl/float32_half_converter_core_defines.svh @@
// Assertion macros for the converter RTL.
`ifndef FLOAT32_HALF_CONVERTER_CORE_DEFINES_SVH
`define FLOAT32_HALF_CONVERTER_CORE_DEFINES_SVH
// Check that a condition implies a property on the same edge.
`define FHC_ASSERT_IMP(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");
// Check that a condition implies a property on the next edge.
`define FHC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");
`endif

@@ hw/rtl/fhc_pkg.sv @@
// Package: types and constants of the single/half converter.
package fhc_pkg;
	localparam logic        FUNC_S2H = 1'b0;
	localparam logic        FUNC_H2S = 1'b1;
	localparam int unsigned NUM_STAGES = 3;
	localparam logic [7:0]  BIAS_DIFF = 8'(127 - 15);
	localparam logic [15:0] HALF_INF = 16'h7c00;
	localparam logic [31:0] SINGLE_INF = 32'h7f80_0000;

	// Decoded item after the first stage.
	typedef struct packed {
		logic        func;
		logic        sign;
		logic        done;      // result already final
		logic [31:0] res;       // final result when done
		logic [7:0]  exp;       // raw exponent (single) or half exponent
		logic [22:0] man;       // mantissa, half mantissa in [9:0]
	} dec_t;

	// Leading-one position of a 10 bit half mantissa, as shift count 1..10.
	function automatic logic [3:0] lz_shift(input logic [9:0] f);
		logic [3:0] n;
		n = 4'd10;
		for (int k = 0; k < 10; k++) begin
			if (f[k]) n = 4'(10 - k);
		end
		return n;
	endfunction
endpackage

@@ hw/rtl/fhc_stream_if.sv @@
// Interface: valid/ready channel with a generic payload.
interface fhc_stream_if #(parameter int unsigned W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/fhc_decode.sv @@
// Stage 1 logic: classify an item and settle special cases.
module fhc_decode (
	input  logic              func,
	input  logic [31:0]       single_in,
	input  logic [15:0]       half_in,
	output fhc_pkg::dec_t     dec
);
	import fhc_pkg::*;
	logic [7:0] e8;
	logic [4:0] e5;
	always_comb begin
		e8 = single_in[30:23];
		e5 = half_in[14:10];
		dec = '0;
		dec.func = func;
		if (func == FUNC_S2H) begin
			dec.sign = single_in[31];
			dec.exp  = e8;
			dec.man  = single_in[22:0];
			if (e8 < 8'd103) begin
				dec.done = 1'b1;
				dec.res  = {16'd0, single_in[31], 15'd0};
			end else if (e8 == 8'hff) begin
				dec.done = 1'b1;
				dec.res  = {16'd0, {single_in[31], 15'd0} | HALF_INF |
					{6'd0, single_in[22:13]} |
					{15'd0, (single_in[22:13] == 10'd0) && (single_in[22:0] != 0)}};
			end else if (e8 > 8'd142) begin
				dec.done = 1'b1;
				dec.res  = {16'd0, {single_in[31], 15'd0} | HALF_INF};
			end
		end else begin
			dec.sign = half_in[15];
			dec.exp  = {3'd0, e5};
			dec.man  = {13'd0, half_in[9:0]};
			if (e5 == 5'd0 && half_in[9:0] == 10'd0) begin
				dec.done = 1'b1;
				dec.res  = {half_in[15], 31'd0};
			end else if (e5 == 5'd31) begin
				dec.done = 1'b1;
				dec.res  = {half_in[15], 31'd0} | SINGLE_INF | {9'd0, half_in[9:0], 13'd0};
			end
		end
	end
endmodule

@@ hw/rtl/fhc_pack.sv @@
// Stage 2 logic: shift and pack the ordinary cases.
module fhc_pack (
	input  fhc_pkg::dec_t dec,
	output logic [31:0]   res
);
	import fhc_pkg::*;
	logic [23:0] sh;
	logic [7:0]  eh;
	logic [3:0]  n;
	logic [9:0]  fn;
	always_comb begin
		sh = '0; eh = '0; n = '0; fn = '0;
		if (dec.done) begin
			res = dec.res;
		end else if (dec.func == FUNC_S2H) begin
			eh = dec.exp - BIAS_DIFF;
			if (dec.exp <= BIAS_DIFF) begin
				// Subnormal half: shift right by 1 - e with hidden one.
				sh = {1'b1, dec.man} >> 5'(8'd113 - dec.exp);
				res = {16'd0, dec.sign, 5'd0, sh[22:13]};
			end else begin
				res = {16'd0, dec.sign, eh[4:0], dec.man[22:13]};
			end
		end else begin
			if (dec.exp[4:0] == 5'd0) begin
				n  = lz_shift(dec.man[9:0]);
				fn = dec.man[9:0] << n;
				res = {dec.sign, 8'(8'd113 - {4'd0, n}), fn, 13'd0};
			end else begin
				res = {dec.sign, dec.exp + BIAS_DIFF, dec.man[9:0], 13'd0};
			end
		end
	end
endmodule

@@ hw/rtl/float32_half_converter_core.sv @@
// Top level: pipelined single/half precision converter.
// Channel | Direction | Payload
// in_ch   | sink      | {func, single_in[31:0], half_in[15:0]}
// out_ch  | source    | {half_out[15:0], single_out[31:0]}
// Registered stages: decode, pack, output register; one transaction per cycle while out_ch does not stall.
// Each stage advances when the next is empty or moving, so stalls hold data.
// Reset clears the valid bits only; payload registers are left as they are.
module float32_half_converter_core (
	input logic clk,
	input logic arst_n,
	fhc_stream_if.sink   in_ch,
	fhc_stream_if.source out_ch
);
	import fhc_pkg::*;
	`include "float32_half_converter_core_defines.svh"

	dec_t        dec_c, dec_s1;
	logic        v_s1, v_s2, v_s3;
	logic        func_s2;
	logic [31:0] res_c, res_s2;
	logic [47:0] out_s3;
	logic        adv1, adv2, adv3;

	// Stage 1: classify the incoming transaction.
	fhc_decode u_dec (
		.func(in_ch.data[48]), .single_in(in_ch.data[47:16]),
		.half_in(in_ch.data[15:0]), .dec(dec_c)
	);
	// Stage 2: normalise and pack.
	fhc_pack u_pack (.dec(dec_s1), .res(res_c));

	assign adv3 = !v_s3 || out_ch.ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ch.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_ch.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) dec_s1 <= dec_c;
		if (adv2) begin
			res_s2  <= res_c;
			func_s2 <= dec_s1.func;
		end
		// Zero the field of the direction not chosen.
		if (adv3) out_s3 <= (func_s2 == FUNC_S2H) ? {res_s2[15:0], 32'd0} : {16'd0, res_s2};
	end

	assign out_ch.valid = v_s3;
	assign out_ch.data  = out_s3;

	`FHC_ASSERT_NEXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
	`FHC_ASSERT_NEXT(a_fill, clk, arst_n, v_s2 && adv3, v_s3)
	`FHC_ASSERT_IMP(a_bp, clk, arst_n, v_s1 && v_s2 && v_s3 && !out_ch.ready, !in_ch.ready)
endmodule

@@ dv/fhc_tb_pkg.sv @@
// Scoreboard class for the single/half converter testbench.
package fhc_tb_pkg;
	import fhc_pkg::*;

	typedef struct packed {
		logic [15:0] half_val;
		logic [31:0] single_val;
	} conv_res_t;

	class conv_scoreboard;
		conv_res_t pending[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		static function logic [15:0] to_half(logic [31:0] x);
			logic [15:0] s;
			int e;
			logic [31:0] f;
			logic [9:0] top;
			s = {x[31], 15'd0};
			e = int'(x[30:23]) - int'(BIAS_DIFF);
			f = {9'd0, x[22:0]};
			if (e <= 0) begin
				if (e < -10) return s;
				f = (f | 32'h0080_0000) >> (1 - e);
				return s | f[28:13];
			end
			if (x[30:23] == 8'hff) begin
				if (f == 0) return s | HALF_INF;
				top = f[22:13];
				return s | HALF_INF | {6'd0, top} | (top == 10'd0 ? 16'd1 : 16'd0);
			end
			if (e > 30) return s | HALF_INF;
			return s | 16'(e << 10) | {6'd0, f[22:13]};
		endfunction

		static function logic [31:0] to_single(logic [15:0] h);
			int e;
			logic [9:0] f;
			logic [10:0] m;
			e = int'(h[14:10]);
			f = h[9:0];
			if (e == 0) begin
				if (f == 10'd0) return {h[15], 31'd0};
				m = {1'b0, f};
				while (!m[10]) begin
					m = m << 1;
					e--;
				end
				e++;
				f = m[9:0];
			end else if (e == 31) begin
				return {h[15], 31'd0} | SINGLE_INF | {9'd0, f, 13'd0};
			end
			e = e + int'(BIAS_DIFF);
			return {h[15], 8'(e), f, 13'd0};
		endfunction

		// Note one accepted input transaction.
		function void note_input(logic func, logic [31:0] s_in, logic [15:0] h_in);
			conv_res_t r;
			r = '0;
			if (func == FUNC_S2H) r.half_val = to_half(s_in);
			else r.single_val = to_single(h_in);
			pending.push_back(r);
		endfunction

		// Check one accepted result; returns 1 on failure.
		function bit check_result(logic [15:0] h, logic [31:0] s);
			conv_res_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h %h", h, s);
				return 1;
			end
			e = pending.pop_front();
			if (h !== e.half_val || s !== e.single_val) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: half exp %h got %h, single exp %h got %h",
						e.half_val, h, e.single_val, s);
				return 1;
			end
			return 0;
		endfunction
	endclass
endpackage

@@ dv/tb_float32_half_converter_core.sv @@
// Testbench top for the single/half precision converter.
module tb_float32_half_converter_core;
	timeunit 1ns;
	timeprecision 1ps;
	import fhc_pkg::*;
	import fhc_tb_pkg::*;

	logic clk;
	logic arst_n;
	fhc_stream_if #(.W(49)) in_ch ();
	fhc_stream_if #(.W(48)) out_ch ();

	float32_half_converter_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	conv_scoreboard sb;
	bit failed;
	bit calm;         // final stretch: no idling on either side

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Note inputs and check results at the rising edge.
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			sb.note_input(in_ch.data[48], in_ch.data[47:16], in_ch.data[15:0]);
		if (arst_n && out_ch.valid && out_ch.ready)
			if (sb.check_result(out_ch.data[47:32], out_ch.data[31:0])) failed = 1'b1;
	end

	// Receiver: stall in random bursts until the calm final stretch.
	initial begin
		int n;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				out_ch.ready <= 1'b0;
				n = int'($urandom_range(1, 16));
				repeat (n) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	// Drive one transaction; hold until the handshake completes.
	task automatic send_item(logic func, logic [31:0] s_in, logic [15:0] h_in);
		int n;
		if (!calm && $urandom_range(0, 9) == 0) begin
			in_ch.valid <= 1'b0;
			n = int'($urandom_range(1, 16));
			repeat (n) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= {func, s_in, h_in};
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	// Build a random single with an exponent biased towards the interesting ranges.
	function automatic logic [31:0] rand_single();
		logic [7:0] e;
		case ($urandom_range(0, 5))
			0: e = 8'($urandom_range(100, 115));
			1: e = 8'($urandom_range(140, 145));
			2: e = 8'hff;
			3: e = 8'h00;
			default: e = 8'($urandom);
		endcase
		return {1'($urandom), e, 23'($urandom)};
	endfunction

	function automatic logic [15:0] rand_half();
		logic [4:0] e;
		case ($urandom_range(0, 3))
			0: e = 5'd0;
			1: e = 5'd31;
			default: e = 5'($urandom);
		endcase
		return {1'($urandom), e, 10'($urandom)};
	endfunction

	initial begin
		logic [31:0] dir_s[$];
		logic [15:0] dir_h[$];
		sb = new();
		failed = 1'b0;
		calm = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: zeros, deep underflow, subnormal edges, overflow, inf, NaN.
		dir_s = '{32'h0000_0000, 32'h8000_0000, 32'h3380_0000, 32'h3300_0001,
			32'h387f_ffff, 32'h3880_0000, 32'h477f_e000, 32'hc780_0000,
			32'h7f7f_ffff, 32'h7f80_0000, 32'hff80_0000, 32'h7f80_0001,
			32'h7fc0_0000, 32'hffff_ffff};
		dir_h = '{16'h0000, 16'h8000, 16'h0001, 16'h03ff, 16'h8200, 16'h0400,
			16'h7bff, 16'h7c00, 16'hfc00, 16'h7e01, 16'hffff};
		foreach (dir_s[i]) send_item(FUNC_S2H, dir_s[i], 16'hffff);
		foreach (dir_h[i]) send_item(FUNC_H2S, 32'hffff_ffff, dir_h[i]);

		for (int i = 0; i < 600; i++) begin
			if (i == 300) begin
				// Hold off until the pipe has drained completely.
				in_ch.valid <= 1'b0;
				while (sb.pending.size() != 0) @(negedge clk);
			end
			if (i == 480) calm = 1'b1;
			if ($urandom_range(0, 1))
				send_item(FUNC_S2H, rand_single(), 16'($urandom));
			else
				send_item(FUNC_H2S, $urandom, rand_half());
		end
		in_ch.valid <= 1'b0;

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (!failed && sb.pending.size() == 0)
			$display("tb_float32_half_converter_core passed");
		else
			$display("tb_float32_half_converter_core failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2ms;
		$display("tb_float32_half_converter_core failed");
		$finish;
	end
endmodule
